FILE: rtl/core/segment_pair_intersection_2d_defines.svh
// assertion macros shared by the segment pair intersection rtl
`ifndef SEGMENT_PAIR_INTERSECTION_2D_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECTION_2D_DEFINES_SVH

// clocked check, off while reset is held
`define SPI2D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("spi2d check failed");

// same-cycle implication check
`define SPI2D_ASSERT_IMPL(lbl, ante, cons) \
  `SPI2D_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: rtl/core/spi2d_pkg.sv
// shared constants and types for the segment pair intersection block
package spi2d_pkg;

  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // result flag positions in out_tuser
  localparam int USER_W   = 3;
  localparam int UIDX_HIT = 0;
  localparam int UIDX_PAR = 1;
  localparam int UIDX_SAT = 2;

  // control travelling with each item through the divider chain
  typedef struct packed {
    logic valid;
    logic par;
    logic negx;
    logic negy;
  } spi2d_ctl_t;

endpackage

FILE: rtl/core/spi2d_front.sv
// setup pipeline: line coefficients, determinants, magnitudes and bounds
module spi2d_front import spi2d_pkg::*; #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [W-1:0]     ax0,
  input  logic signed [W-1:0]     ay0,
  input  logic        [W-1:0]     az,
  input  logic signed [W-1:0]     ax1,
  input  logic signed [W-1:0]     ay1,
  input  logic signed [W-1:0]     bx0,
  input  logic signed [W-1:0]     by0,
  input  logic signed [W-1:0]     bx1,
  input  logic signed [W-1:0]     by1,
  input  logic [TOL_W-1:0]        tol,
  output spi2d_ctl_t              ctl_o,
  output logic [2*W+2:0]          dmag_o,
  output logic [3*W+3:0]          nx_o,
  output logic [3*W+3:0]          ny_o,
  output logic [W+4*(W+2)-1:0]    side_o
);

  localparam int BW = W + 2;        // bound width
  localparam int CW = 2 * W + 2;    // c coefficient width
  localparam int DW = 2 * W + 3;    // determinant width
  localparam int NW = 3 * W + 4;    // numerator width
  localparam int L  = W + 1;        // split point of c for the products
  localparam int SW = W + 4 * BW;

  // stage valid bits
  logic [6:0] v_r;

  // stage 1: coefficient differences and per-segment bounds
  logic signed [W:0]    a1_r, b1_r, a2_r, b2_r;
  logic signed [W-1:0]  ax0_r, ay0_r, bx0_r, by0_r;
  logic [W-1:0]         z1_r;
  logic signed [BW-1:0] lax_r, hax_r, lay_r, hay_r, lbx_r, hbx_r, lby_r, hby_r;
  logic signed [BW-1:0] tol_s;

  assign tol_s = $signed(BW'(tol));

  function automatic logic signed [BW-1:0] lo_of(input logic signed [W-1:0] p,
                                                  input logic signed [W-1:0] q,
                                                  input logic signed [BW-1:0] t);
    logic signed [W-1:0] m;
    m = (p < q) ? p : q;
    return BW'(m) - t;
  endfunction

  function automatic logic signed [BW-1:0] hi_of(input logic signed [W-1:0] p,
                                                  input logic signed [W-1:0] q,
                                                  input logic signed [BW-1:0] t);
    logic signed [W-1:0] m;
    m = (p < q) ? q : p;
    return BW'(m) + t;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= (W+1)'(ay1) - (W+1)'(ay0);
      b1_r  <= (W+1)'(ax0) - (W+1)'(ax1);
      a2_r  <= (W+1)'(by1) - (W+1)'(by0);
      b2_r  <= (W+1)'(bx0) - (W+1)'(bx1);
      ax0_r <= ax0;
      ay0_r <= ay0;
      bx0_r <= bx0;
      by0_r <= by0;
      z1_r  <= az;
      lax_r <= lo_of(ax0, ax1, tol_s);
      hax_r <= hi_of(ax0, ax1, tol_s);
      lay_r <= lo_of(ay0, ay1, tol_s);
      hay_r <= hi_of(ay0, ay1, tol_s);
      lbx_r <= lo_of(bx0, bx1, tol_s);
      hbx_r <= hi_of(bx0, bx1, tol_s);
      lby_r <= lo_of(by0, by1, tol_s);
      hby_r <= hi_of(by0, by1, tol_s);
    end
  end

  // stage 2: first products, combined bounds
  logic signed [2*W:0]   m1_r, m2_r, m3_r, m4_r;
  logic signed [2*W+1:0] m5_r, m6_r;
  logic signed [W:0]     a1b_r, b1b_r, a2b_r, b2b_r;
  logic [SW-1:0]         side2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r    <= ax0_r * a1_r;
      m2_r    <= ay0_r * b1_r;
      m3_r    <= bx0_r * a2_r;
      m4_r    <= by0_r * b2_r;
      m5_r    <= a1_r * b2_r;
      m6_r    <= a2_r * b1_r;
      a1b_r   <= a1_r;
      b1b_r   <= b1_r;
      a2b_r   <= a2_r;
      b2b_r   <= b2_r;
      side2_r <= {z1_r,
                  (lax_r > lbx_r) ? lax_r : lbx_r,
                  (hax_r < hbx_r) ? hax_r : hbx_r,
                  (lay_r > lby_r) ? lay_r : lby_r,
                  (hay_r < hby_r) ? hay_r : hby_r};
    end
  end

  // stage 3: c coefficients and determinant
  logic signed [CW-1:0] c1_r, c2_r;
  logic signed [DW-1:0] d3_r;
  logic signed [W:0]    a1c_r, b1c_r, a2c_r, b2c_r;
  logic [SW-1:0]        side3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= CW'(m1_r) + CW'(m2_r);
      c2_r    <= CW'(m3_r) + CW'(m4_r);
      d3_r    <= DW'(m5_r) - DW'(m6_r);
      a1c_r   <= a1b_r;
      b1c_r   <= b1b_r;
      a2c_r   <= a2b_r;
      b2c_r   <= b2b_r;
      side3_r <= side2_r;
    end
  end

  // stage 4: partial products of c times a coefficient
  logic signed [2*W+2:0] p1l_r, p2l_r, p3l_r, p4l_r;
  logic signed [2*W+1:0] p1h_r, p2h_r, p3h_r, p4h_r;
  logic signed [DW-1:0]  d4_r;
  logic [SW-1:0]         side4_r;
  logic signed [W+1:0]   c1lo, c2lo;
  logic signed [W:0]     c1hi, c2hi;

  assign c1lo = $signed({1'b0, c1_r[L-1:0]});
  assign c2lo = $signed({1'b0, c2_r[L-1:0]});
  assign c1hi = c1_r[CW-1:L];
  assign c2hi = c2_r[CW-1:L];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1l_r   <= c1lo * b2c_r;
      p1h_r   <= c1hi * b2c_r;
      p2l_r   <= c2lo * b1c_r;
      p2h_r   <= c2hi * b1c_r;
      p3l_r   <= c2lo * a1c_r;
      p3h_r   <= c2hi * a1c_r;
      p4l_r   <= c1lo * a2c_r;
      p4h_r   <= c1hi * a2c_r;
      d4_r    <= d3_r;
      side4_r <= side3_r;
    end
  end

  // stage 5: recombine partial products
  logic signed [NW-1:0] pp1_r, pp2_r, pp3_r, pp4_r;
  logic signed [DW-1:0] d5_r;
  logic [SW-1:0]        side5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pp1_r   <= (NW'(p1h_r) <<< L) + NW'(p1l_r);
      pp2_r   <= (NW'(p2h_r) <<< L) + NW'(p2l_r);
      pp3_r   <= (NW'(p3h_r) <<< L) + NW'(p3l_r);
      pp4_r   <= (NW'(p4h_r) <<< L) + NW'(p4l_r);
      d5_r    <= d4_r;
      side5_r <= side4_r;
    end
  end

  // stage 6: numerator determinants
  logic signed [NW-1:0] dx_r, dy_r;
  logic signed [DW-1:0] d6_r;
  logic [SW-1:0]        side6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= pp1_r - pp2_r;
      dy_r    <= pp3_r - pp4_r;
      d6_r    <= d5_r;
      side6_r <= side5_r;
    end
  end

  // stage 7: magnitudes and quotient signs
  logic           par7_r, negx7_r, negy7_r;
  logic [DW-1:0]  dm_r;
  logic [NW-1:0]  nx_r, ny_r;
  logic [SW-1:0]  side7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r    <= d6_r[DW-1] ? DW'(-d6_r) : DW'(d6_r);
      nx_r    <= dx_r[NW-1] ? NW'(-dx_r) : NW'(dx_r);
      ny_r    <= dy_r[NW-1] ? NW'(-dy_r) : NW'(dy_r);
      par7_r  <= (d6_r == '0);
      negx7_r <= dx_r[NW-1] ^ d6_r[DW-1];
      negy7_r <= dy_r[NW-1] ^ d6_r[DW-1];
      side7_r <= side6_r;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_comb begin
    ctl_o.valid = v_r[6];
    ctl_o.par   = par7_r;
    ctl_o.negx  = negx7_r;
    ctl_o.negy  = negy7_r;
  end

  assign dmag_o = dm_r;
  assign nx_o   = nx_r;
  assign ny_o   = ny_r;
  assign side_o = side7_r;

endmodule

FILE: rtl/core/spi2d_div_cell.sv
// one restoring division step for the x and y quotients
module spi2d_div_cell import spi2d_pkg::*; #(
  parameter int NW = 100,
  parameter int DW = 67,
  parameter int SW = 176
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  spi2d_ctl_t    ctl_i,
  input  logic [DW-1:0] d_i,
  input  logic [DW-1:0] rx_i,
  input  logic [NW-1:0] qx_i,
  input  logic [DW-1:0] ry_i,
  input  logic [NW-1:0] qy_i,
  input  logic [SW-1:0] side_i,
  output spi2d_ctl_t    ctl_o,
  output logic [DW-1:0] d_o,
  output logic [DW-1:0] rx_o,
  output logic [NW-1:0] qx_o,
  output logic [DW-1:0] ry_o,
  output logic [NW-1:0] qy_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0] tx, ty, dd, sx, sy;
  logic        gx, gy;

  // shift in next numerator bit, trial subtract
  assign dd = {1'b0, d_i};
  assign tx = {rx_i, qx_i[NW-1]};
  assign ty = {ry_i, qy_i[NW-1]};
  assign gx = (tx >= dd);
  assign gy = (ty >= dd);
  assign sx = tx - dd;
  assign sy = ty - dd;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_o.par  <= ctl_i.par;
      ctl_o.negx <= ctl_i.negx;
      ctl_o.negy <= ctl_i.negy;
      d_o        <= d_i;
      rx_o       <= gx ? sx[DW-1:0] : tx[DW-1:0];
      ry_o       <= gy ? sy[DW-1:0] : ty[DW-1:0];
      qx_o       <= {qx_i[NW-2:0], gx};
      qy_o       <= {qy_i[NW-2:0], gy};
      side_o     <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (adv) begin
      ctl_o.valid <= ctl_i.valid;
    end
  end

endmodule

FILE: rtl/core/spi2d_back.sv
// quotient sign, containment test, clamp and output register
module spi2d_back import spi2d_pkg::*; #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  spi2d_ctl_t            ctl_i,
  input  logic [3*W+3:0]        qx_i,
  input  logic [3*W+3:0]        qy_i,
  input  logic [W+4*(W+2)-1:0]  side_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic                  par_o,
  output logic                  sat_o,
  output logic [W-1:0]          x_o,
  output logic [W-1:0]          y_o,
  output logic [W-1:0]          z_o
);

  localparam int BW = W + 2;
  localparam int NW = 3 * W + 4;
  localparam int QW = NW + 1;
  localparam int SW = W + 4 * BW;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // stage 1: signed quotients
  logic                 v1_r;
  logic                 par1_r;
  logic signed [QW-1:0] sx_r, sy_r;
  logic [SW-1:0]        side1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      par1_r  <= ctl_i.par;
      sx_r    <= ctl_i.negx ? -$signed(QW'(qx_i)) : $signed(QW'(qx_i));
      sy_r    <= ctl_i.negy ? -$signed(QW'(qy_i)) : $signed(QW'(qy_i));
      side1_r <= side_i;
    end
  end

  // unpack bounds
  logic signed [BW-1:0] lox, hix, loy, hiy;
  logic [W-1:0]         zz;
  assign {zz, lox, hix, loy, hiy} = side1_r;

  // containment and clamp
  logic in_x, in_y, hx, lx, hy, ly;
  assign in_x = (sx_r >= QW'(lox)) && (sx_r <= QW'(hix));
  assign in_y = (sy_r >= QW'(loy)) && (sy_r <= QW'(hiy));
  assign hx = sx_r > QW'(CMAX);
  assign lx = sx_r < QW'(CMIN);
  assign hy = sy_r > QW'(CMAX);
  assign ly = sy_r < QW'(CMIN);

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      par_o <= par1_r;
      hit_o <= !par1_r && in_x && in_y;
      sat_o <= !par1_r && (hx || lx || hy || ly);
      x_o   <= par1_r ? '0 : hx ? CMAX : lx ? CMIN : sx_r[W-1:0];
      y_o   <= par1_r ? '0 : hy ? CMAX : ly ? CMIN : sy_r[W-1:0];
      z_o   <= par1_r ? '0 : zz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv) begin
      v1_r    <= ctl_i.valid;
      valid_o <= v1_r;
    end
  end

endmodule

FILE: rtl/core/segment_pair_intersection_2d.sv
// top level: crossing point of two planar segments by cramer's rule
//
// in channel (in_tvalid/in_tready/in_tdata) takes one item per cycle: eight
// signed fixed-point coordinates of two segments plus the z of the first
// segment's start. out channel returns one item for every input item, in
// order: crossing x, y, z in out_tdata and hit, parallel, saturated flags
// in out_tuser. cfg_we/cfg_wdata load the containment tolerance (reset 7).
// the pipeline is seven setup stages, one divider cell per numerator bit
// (3*COORD_WIDTH+4 cells, each retiring one quotient bit of x and y), then
// two result stages. throughput is one item per cycle; the whole pipeline
// advances together. when out_tready is low with a result waiting, the
// pipeline holds and in_tready drops in the same cycle; no item is lost or
// repeated. reset (rst_n low, synchronous) empties the pipeline and
// restores the tolerance; payload registers are not cleared.
// parallel or degenerate segments give parallel=1 and all other fields 0.
module segment_pair_intersection_2d import spi2d_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  // cross_x, cross_y, cross_z
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // hit, parallel, saturated
  output logic [USER_W-1:0]                     out_tuser,
  input  logic                                  cfg_we,
  input  logic [TOL_W-1:0]                      cfg_wdata
);

`include "segment_pair_intersection_2d_defines.svh"

  localparam int W   = COORD_WIDTH;
  localparam int BW  = W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int NW  = 3 * W + 4;
  localparam int SW  = W + 4 * BW;
  localparam int ODW = ((3*W+7)/8)*8;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic adv;
  logic [TOL_W-1:0] tol_r;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // whole pipeline moves unless a result is stuck at the output
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // divider chain taps
  spi2d_ctl_t    ctl_c  [0:NW];
  logic [DW-1:0] d_c    [0:NW];
  logic [DW-1:0] rx_c   [0:NW];
  logic [NW-1:0] qx_c   [0:NW];
  logic [DW-1:0] ry_c   [0:NW];
  logic [NW-1:0] qy_c   [0:NW];
  logic [SW-1:0] side_c [0:NW];

  spi2d_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .ax0      ($signed(in_tdata[0*W +: W])),
    .ay0      ($signed(in_tdata[1*W +: W])),
    .az       (in_tdata[2*W +: W]),
    .ax1      ($signed(in_tdata[3*W +: W])),
    .ay1      ($signed(in_tdata[4*W +: W])),
    .bx0      ($signed(in_tdata[5*W +: W])),
    .by0      ($signed(in_tdata[6*W +: W])),
    .bx1      ($signed(in_tdata[7*W +: W])),
    .by1      ($signed(in_tdata[8*W +: W])),
    .tol      (tol_r),
    .ctl_o    (ctl_c[0]),
    .dmag_o   (d_c[0]),
    .nx_o     (qx_c[0]),
    .ny_o     (qy_c[0]),
    .side_o   (side_c[0])
  );

  assign rx_c[0] = '0;
  assign ry_c[0] = '0;

  // one cell per quotient bit
  for (genvar i = 0; i < NW; i++) begin : g_cell
    spi2d_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (ctl_c[i]),
      .d_i    (d_c[i]),
      .rx_i   (rx_c[i]),
      .qx_i   (qx_c[i]),
      .ry_i   (ry_c[i]),
      .qy_i   (qy_c[i]),
      .side_i (side_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .d_o    (d_c[i+1]),
      .rx_o   (rx_c[i+1]),
      .qx_o   (qx_c[i+1]),
      .ry_o   (ry_c[i+1]),
      .qy_o   (qy_c[i+1]),
      .side_o (side_c[i+1])
    );
  end

  logic         hit, par, sat;
  logic [W-1:0] cx, cy, cz;

  spi2d_back #(.W(W)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (ctl_c[NW]),
    .qx_i    (qx_c[NW]),
    .qy_i    (qy_c[NW]),
    .side_i  (side_c[NW]),
    .valid_o (out_tvalid),
    .hit_o   (hit),
    .par_o   (par),
    .sat_o   (sat),
    .x_o     (cx),
    .y_o     (cy),
    .z_o     (cz)
  );

  // pack result
  assign out_tdata = ODW'({cz, cy, cx});
  always_comb begin
    out_tuser           = '0;
    out_tuser[UIDX_HIT] = hit;
    out_tuser[UIDX_PAR] = par;
    out_tuser[UIDX_SAT] = sat;
  end

  // checks
  `SPI2D_ASSERT_IMPL(a_par_clean, out_tvalid && par, !hit && !sat && (cx | cy | cz) == '0)
  `SPI2D_ASSERT_IMPL(a_sat_edge, out_tvalid && sat, cx == CMAX || cx == CMIN || cy == CMAX || cy == CMIN)
  `SPI2D_ASSERT(a_cfg_load, cfg_we |=> tol_r == $past(cfg_wdata))

endmodule
